>>> rtl/mfps_pkg.sv
// ----------------------------------------------------------------------------
// mfps_pkg: shared types and constants of the motorized fader servo
// Command codes, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package mfps_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_TARGET  = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_TOUCH   = 2'd3
  } cmd_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_MAX = 3'd4;

  localparam logic signed [15:0] PROP_GAIN_RST  = 16'sd230;
  localparam logic signed [15:0] INTEG_GAIN_RST = 16'sd0;
  localparam logic signed [15:0] DERIV_GAIN_RST = 16'sd12800;
  localparam logic [9:0]         REPORT_THR_RST = 10'd4;
  localparam logic [9:0]         POS_MAX_RST    = 10'd1023;

  localparam int POS_W   = 10;
  localparam int ERR_W   = 11;
  localparam int DERR_W  = 12;
  localparam int SUM_W   = 24;
  localparam int LREP_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int PP_W    = GAIN_W + ERR_W;
  localparam int PI_W    = GAIN_W + SUM_W;
  localparam int PD_W    = GAIN_W + DERR_W;
  localparam int ACC_W   = PI_W + 2;
  localparam int DUTY_W  = 8;

  localparam logic [LREP_W-1:0] LAST_REPORT_RST = 16'hFFFF;

  typedef struct packed {
    logic [DUTY_W-1:0] fwd;
    logic [DUTY_W-1:0] rev;
  } drive_t;

endpackage

>>> rtl/motor_fader_position_servo.sv
// ----------------------------------------------------------------------------
// motor_fader_position_servo: PID position servo for a bank of faders
// Per-fader target, flags and PID state in flip-flops; three-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one request per cycle while in_ready is high and returns the result
// of a position sample through the input, product and output registers.
// Stage one reads and updates the addressed fader's state, so a
// request for the same fader in the next cycle already sees it; stage two
// holds the three gain products; stage three sums, clamps and splits the
// effort. Only samples for an existing fader produce a result; other requests
// leave the pipeline after stage one. A held output does not block intake
// until the stages behind it are full.
module motor_fader_position_servo #(
  parameter int FADER_COUNT = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [3:0]        in_fader_index,
  input  logic signed [15:0] in_value,
  input  logic              in_touch_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_fader_id,
  output logic [7:0]        out_drive_forward,
  output logic [7:0]        out_drive_reverse,
  output logic              out_motor_enabled,
  output logic              out_report_valid,
  output logic [9:0]        out_report_position,
  input  logic              cfg_we,
  input  logic [mfps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfps_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;

  // configuration
  logic signed [15:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [9:0]         report_thr_r, pos_max_r;

  // per-fader state
  logic [mfps_pkg::POS_W-1:0]         target_r   [FADER_COUNT];
  logic                               released_r [FADER_COUNT];
  logic                               touched_r  [FADER_COUNT];
  logic signed [mfps_pkg::SUM_W-1:0]  esum_r     [FADER_COUNT];
  logic signed [mfps_pkg::ERR_W-1:0]  old_err_r  [FADER_COUNT];
  logic [mfps_pkg::LREP_W-1:0]        last_rep_r [FADER_COUNT];

  // stage one
  logic              s1_v_r, s1_v_nxt;
  mfps_pkg::cmd_t    s1_cmd_r;
  logic [3:0]        s1_fader_r;
  logic signed [15:0] s1_value_r;
  logic              s1_touch_r;

  // stage two
  logic              s2_v_r, s2_v_nxt;
  logic [3:0]        s2_fader_r;
  logic              s2_en_r, s2_rv_r;
  logic [9:0]        s2_rp_r;
  logic signed [mfps_pkg::PP_W-1:0] s2_pp_r;
  logic signed [mfps_pkg::PI_W-1:0] s2_pi_r;
  logic signed [mfps_pkg::PD_W-1:0] s2_pd_r;

  // output
  logic              out_v_r, out_v_nxt;
  logic [3:0]        out_fader_r;
  logic [7:0]        out_fwd_r, out_rev_r;
  logic              out_en_r, out_rv_r;
  logic [9:0]        out_rp_r;

  // handshake
  logic in_fire, out_free, s2_go, s2_free, s1_go, s1_in_range, s1_res;

  // stage one datapath
  logic [IDX_W-1:0]                  fi;
  logic [mfps_pkg::POS_W-1:0]        pos;
  logic                              hold;
  logic signed [mfps_pkg::ERR_W-1:0] err;
  logic signed [mfps_pkg::SUM_W:0]   sum_wide;
  logic signed [mfps_pkg::SUM_W-1:0] sum_sat;
  logic signed [mfps_pkg::DERR_W-1:0] derr;
  logic signed [16:0]                rep_diff;
  logic [16:0]                       rep_abs;
  logic                              rpt;

  mfps_pkg::drive_t drive;

  assign out_free    = !out_v_r || out_ready;
  assign s2_go       = s2_v_r && out_free;
  assign s2_free     = !s2_v_r || s2_go;
  assign s1_in_range = {1'b0, s1_fader_r} < 5'(FADER_COUNT);
  assign s1_res      = s1_in_range && (s1_cmd_r == mfps_pkg::CMD_SAMPLE);
  assign s1_go       = s1_v_r && (!s1_res || s2_free);
  assign in_ready    = !s1_v_r || s1_go;
  assign in_fire     = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
    s2_v_nxt = (s1_go && s1_res) ? 1'b1 : (s2_go ? 1'b0 : s2_v_r);
    out_v_nxt = s2_go ? 1'b1 : ((out_v_r && out_ready) ? 1'b0 : out_v_r);
  end

  always_comb begin
    fi = s1_fader_r[IDX_W-1:0];
    if (s1_value_r[15]) begin
      pos = '0;
    end else if (s1_value_r[14:0] > {5'd0, pos_max_r}) begin
      pos = pos_max_r;
    end else begin
      pos = s1_value_r[9:0];
    end
    hold = !released_r[fi] && !touched_r[fi];
    err  = $signed({1'b0, target_r[fi]}) - $signed({1'b0, pos});
    sum_wide = {esum_r[fi][mfps_pkg::SUM_W-1], esum_r[fi]}
             + {{(mfps_pkg::SUM_W + 1 - mfps_pkg::ERR_W){err[mfps_pkg::ERR_W-1]}}, err};
    // saturate on signed overflow of the 24-bit sum
    if (sum_wide[mfps_pkg::SUM_W] != sum_wide[mfps_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[mfps_pkg::SUM_W] ? {1'b1, {(mfps_pkg::SUM_W-1){1'b0}}}
                                          : {1'b0, {(mfps_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[mfps_pkg::SUM_W-1:0];
    end
    derr = {err[mfps_pkg::ERR_W-1], err}
         - {old_err_r[fi][mfps_pkg::ERR_W-1], old_err_r[fi]};
    rep_diff = $signed({7'd0, pos}) - $signed({1'b0, last_rep_r[fi]});
    rep_abs  = rep_diff[16] ? 17'(-rep_diff) : 17'(rep_diff);
    rpt      = rep_abs > {7'd0, report_thr_r};
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= mfps_pkg::PROP_GAIN_RST;
      integ_gain_r <= mfps_pkg::INTEG_GAIN_RST;
      deriv_gain_r <= mfps_pkg::DERIV_GAIN_RST;
      report_thr_r <= mfps_pkg::REPORT_THR_RST;
      pos_max_r    <= mfps_pkg::POS_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mfps_pkg::REG_PROP_GAIN:    prop_gain_r  <= $signed(cfg_wdata);
        mfps_pkg::REG_INTEG_GAIN:   integ_gain_r <= $signed(cfg_wdata);
        mfps_pkg::REG_DERIV_GAIN:   deriv_gain_r <= $signed(cfg_wdata);
        mfps_pkg::REG_REPORT_THR:   report_thr_r <= cfg_wdata[9:0];
        mfps_pkg::REG_POSITION_MAX: pos_max_r    <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // fader state: update once, as the request leaves stage one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FADER_COUNT; i++) begin
        target_r[i]   <= '0;
        released_r[i] <= 1'b1;
        touched_r[i]  <= 1'b0;
        esum_r[i]     <= '0;
        old_err_r[i]  <= '0;
        last_rep_r[i] <= mfps_pkg::LAST_REPORT_RST;
      end
    end else if (s1_go && s1_in_range) begin
      case (s1_cmd_r)
        mfps_pkg::CMD_TARGET: begin
          target_r[fi]   <= pos;
          released_r[fi] <= 1'b0;
        end
        mfps_pkg::CMD_RELEASE: released_r[fi] <= 1'b1;
        mfps_pkg::CMD_TOUCH:   touched_r[fi]  <= s1_touch_r;
        mfps_pkg::CMD_SAMPLE: begin
          if (hold) begin
            esum_r[fi]    <= sum_sat;
            old_err_r[fi] <= err;
          end else if (rpt) begin
            last_rep_r[fi] <= {6'd0, pos};
          end
        end
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= mfps_pkg::cmd_t'(in_cmd);
      s1_fader_r <= in_fader_index;
      s1_value_r <= in_value;
      s1_touch_r <= in_touch_value;
    end
    if (s1_go && s1_res) begin
      s2_fader_r <= s1_fader_r;
      s2_en_r    <= hold;
      s2_rv_r    <= !hold && rpt;
      s2_rp_r    <= (!hold && rpt) ? pos : '0;
      s2_pp_r    <= prop_gain_r * err;
      s2_pi_r    <= integ_gain_r * sum_sat;
      s2_pd_r    <= deriv_gain_r * derr;
    end
    if (s2_go) begin
      out_fader_r <= s2_fader_r;
      out_en_r    <= s2_en_r;
      out_rv_r    <= s2_rv_r;
      out_rp_r    <= s2_rp_r;
      out_fwd_r   <= s2_en_r ? drive.fwd : '0;
      out_rev_r   <= s2_en_r ? drive.rev : '0;
    end
  end

  mfps_effort u_effort (
    .prod_p (s2_pp_r),
    .prod_i (s2_pi_r),
    .prod_d (s2_pd_r),
    .drive  (drive)
  );

  assign out_valid           = out_v_r;
  assign out_fader_id        = out_fader_r;
  assign out_drive_forward   = out_fwd_r;
  assign out_drive_reverse   = out_rev_r;
  assign out_motor_enabled   = out_en_r;
  assign out_report_valid    = out_rv_r;
  assign out_report_position = out_rp_r;

endmodule

>>> rtl/mfps_effort.sv
// ----------------------------------------------------------------------------
// mfps_effort: PID accumulator and H-bridge split
// Sums the three Q8.8 products, truncates toward zero, clamps to +-255 and
// splits the effort into forward and reverse duty.
// ----------------------------------------------------------------------------
module mfps_effort (
  input  logic signed [mfps_pkg::PP_W-1:0] prod_p,
  input  logic signed [mfps_pkg::PI_W-1:0] prod_i,
  input  logic signed [mfps_pkg::PD_W-1:0] prod_d,
  output mfps_pkg::drive_t                 drive
);

  logic signed [mfps_pkg::ACC_W-1:0] acc;
  logic [mfps_pkg::ACC_W-1:0]        mag;
  logic [mfps_pkg::DUTY_W-1:0]       duty;
  logic                              neg;

  always_comb begin
    acc = mfps_pkg::ACC_W'(prod_p) + mfps_pkg::ACC_W'(prod_i) + mfps_pkg::ACC_W'(prod_d);
    neg = acc[mfps_pkg::ACC_W-1];
    // magnitude first so the shift truncates toward zero
    mag = neg ? mfps_pkg::ACC_W'(-acc) : mfps_pkg::ACC_W'(acc);
    if (|mag[mfps_pkg::ACC_W-1:16]) begin
      duty = '1;
    end else begin
      duty = mag[15:8];
    end
    drive.fwd = neg ? '0 : duty;
    drive.rev = neg ? duty : '0;
  end

endmodule

>>> tb/sv/tb_motor_fader_position_servo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_fader_position_servo: self-checking bench for the fader servo
// Feeds directed and random fader requests through the valid/ready input,
// predicts the drive or report result of every sample of an existing fader
// with a PID model of its own and compares each result, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_motor_fader_position_servo;

  localparam int FADERS      = 10;
  localparam int RUN_LIMIT   = 500000;
  localparam int SUM_HI      = 8388607;
  localparam int SUM_LO      = -8388608;

  typedef struct {
    mfps_pkg::cmd_t     cmd;
    logic [3:0]         fader;
    logic signed [15:0] value;
    logic               touch;
  } fader_req_t;

  typedef struct {
    logic [3:0] fader_id;
    logic [7:0] fwd;
    logic [7:0] rev;
    logic       motor_on;
    logic       report;
    logic [9:0] report_pos;
  } servo_result_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_cmd         = '0;
  logic [3:0]            in_fader_index = '0;
  logic signed [15:0]    in_value       = '0;
  logic                  in_touch_value = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [3:0]            out_fader_id;
  logic [7:0]            out_drive_forward;
  logic [7:0]            out_drive_reverse;
  logic                  out_motor_enabled;
  logic                  out_report_valid;
  logic [9:0]            out_report_position;
  logic                  cfg_we         = 1'b0;
  logic [mfps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mfps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // servo model: configuration and per-fader state
  logic signed [mfps_pkg::GAIN_W-1:0] kp, ki, kd;
  logic [mfps_pkg::POS_W-1:0]         rep_thr, pos_max;
  logic [mfps_pkg::POS_W-1:0]         tgt      [FADERS];
  logic                               released [FADERS];
  logic                               touched  [FADERS];
  logic signed [mfps_pkg::SUM_W-1:0]  err_sum  [FADERS];
  logic signed [mfps_pkg::ERR_W-1:0]  old_err  [FADERS];
  logic [mfps_pkg::LREP_W-1:0]        last_rep [FADERS];

  fader_req_t    fader_requests[$];
  servo_result_t expected_results[$];
  int            last_sample [16];
  int            send_idle_pct = 0;
  int            stall_pct     = 0;
  int            errors        = 0;
  int            cycles        = 0;
  logic          in_taken      = 1'b0;

  motor_fader_position_servo #(.FADER_COUNT(FADERS)) dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void servo_predict(mfps_pkg::cmd_t cmd, logic [3:0] fi,
                                        logic signed [15:0] val, logic tv);
    servo_result_t r;
    int            v, pmax, pos, gap, err;
    longint        sum, acc, mag;
    if (fi >= FADERS) return;
    v    = int'(val);
    pmax = int'(pos_max);
    pos  = (v < 0) ? 0 : (v > pmax) ? pmax : v;
    r    = '{fader_id: fi, fwd: '0, rev: '0, motor_on: 1'b0, report: 1'b0,
             report_pos: '0};
    case (cmd)
      mfps_pkg::CMD_TARGET: begin
        tgt[fi]      = 10'(pos);
        released[fi] = 1'b0;
      end
      mfps_pkg::CMD_RELEASE: released[fi] = 1'b1;
      mfps_pkg::CMD_TOUCH:   touched[fi]  = tv;
      default: begin
        if (touched[fi] || released[fi]) begin
          gap = pos - int'(last_rep[fi]);
          if (gap < 0) gap = -gap;
          if (gap > int'(rep_thr)) begin
            r.report     = 1'b1;
            r.report_pos = 10'(pos);
            last_rep[fi] = 16'(pos);
          end
        end else begin
          err = int'(tgt[fi]) - pos;
          sum = longint'(err_sum[fi]) + longint'(err);
          if (sum > SUM_HI) sum = longint'(SUM_HI);
          if (sum < SUM_LO) sum = longint'(SUM_LO);
          err_sum[fi] = 24'(sum);
          acc = longint'(kp) * err + longint'(ki) * sum
              + longint'(kd) * (err - int'(old_err[fi]));
          old_err[fi] = 11'(err);
          // truncate toward zero, then clamp to full duty
          mag = ((acc < 0) ? -acc : acc) >>> 8;
          if (mag > 255) mag = 255;
          if (acc < 0) r.rev = mag[7:0];
          else r.fwd = mag[7:0];
          r.motor_on = 1'b1;
        end
        expected_results.push_back(r);
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // monitor: register writes, results and accepted requests
  always @(posedge clk) begin
    servo_result_t e;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          mfps_pkg::REG_PROP_GAIN:    kp      = cfg_wdata;
          mfps_pkg::REG_INTEG_GAIN:   ki      = cfg_wdata;
          mfps_pkg::REG_DERIV_GAIN:   kd      = cfg_wdata;
          mfps_pkg::REG_REPORT_THR:   rep_thr = cfg_wdata[mfps_pkg::POS_W-1:0];
          mfps_pkg::REG_POSITION_MAX: pos_max = cfg_wdata[mfps_pkg::POS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual fader %0d",
                   $time, out_fader_id);
        end else begin
          e = expected_results.pop_front();
          check_field("fader_id", 16'(e.fader_id), 16'(out_fader_id));
          check_field("drive_forward", 16'(e.fwd), 16'(out_drive_forward));
          check_field("drive_reverse", 16'(e.rev), 16'(out_drive_reverse));
          check_field("motor_enabled", 16'(e.motor_on), 16'(out_motor_enabled));
          check_field("report_valid", 16'(e.report), 16'(out_report_valid));
          check_field("report_position", 16'(e.report_pos), 16'(out_report_position));
        end
      end
      if (in_valid && in_ready)
        servo_predict(mfps_pkg::cmd_t'(in_cmd), in_fader_index, in_value,
                      in_touch_value);
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  // driver: hold the request until taken, then advance or idle
  always @(negedge clk) begin
    fader_req_t r;
    if (rst_n && (!in_valid || in_taken)) begin
      if (fader_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        r = fader_requests.pop_front();
        in_cmd         <= r.cmd;
        in_fader_index <= r.fader;
        in_value       <= r.value;
        in_touch_value <= r.touch;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic push_req(mfps_pkg::cmd_t c, int f, int v, logic t);
    fader_req_t r;
    r = '{cmd: c, fader: f[3:0], value: v[15:0], touch: t};
    fader_requests.push_back(r);
  endtask

  task automatic write_reg(logic [mfps_pkg::CFG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[mfps_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(int p, int i, int d, int thr, int pmax);
    write_reg(mfps_pkg::REG_PROP_GAIN, p);
    write_reg(mfps_pkg::REG_INTEG_GAIN, i);
    write_reg(mfps_pkg::REG_DERIV_GAIN, d);
    write_reg(mfps_pkg::REG_REPORT_THR, thr);
    write_reg(mfps_pkg::REG_POSITION_MAX, pmax);
    @(negedge clk);
  endtask

  // requests, results and the pipeline tail all drained
  task automatic wait_idle();
    while (fader_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int small_gain();
    return int'($urandom_range(0, 1200)) - 600;
  endfunction

  function automatic int sample_value(int f);
    int v, thr;
    thr = int'(rep_thr);
    case ($urandom_range(0, 9))
      0: v = $signed(16'($urandom));
      1: begin
        case ($urandom_range(0, 6))
          0: v = -32768;
          1: v = -1;
          2: v = 0;
          3: v = int'(pos_max);
          4: v = int'(pos_max) + 1;
          5: v = 1023;
          default: v = 32767;
        endcase
      end
      2, 3: v = last_sample[f] + int'($urandom_range(0, 2 * thr + 2)) - (thr + 1);
      4, 5: v = (f < FADERS) ? int'(tgt[f]) + int'($urandom_range(0, 16)) - 8
                             : int'($urandom_range(0, 1023));
      default: v = int'($urandom_range(0, 1023));
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    last_sample[f] = v;
    return v;
  endfunction

  task automatic queue_random(int n);
    int made, p, f, v;
    made = 0;
    while (made < n) begin
      p = $urandom_range(0, 99);
      f = ($urandom_range(0, 9) == 0) ? $urandom_range(FADERS, 15)
                                      : $urandom_range(0, FADERS - 1);
      if (f < FADERS) made++;
      if (p < 62) begin
        v = sample_value(f);
        push_req(mfps_pkg::CMD_SAMPLE, f, v, 1'($urandom_range(0, 1)));
      end else if (p < 77) begin
        v = ($urandom_range(0, 4) == 0) ? $signed(16'($urandom))
                                        : int'($urandom_range(0, 1023));
        push_req(mfps_pkg::CMD_TARGET, f, v, 1'($urandom_range(0, 1)));
      end else if (p < 85) begin
        push_req(mfps_pkg::CMD_RELEASE, f, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        push_req(mfps_pkg::CMD_TOUCH, f, $urandom, $urandom_range(0, 99) < 35);
      end
    end
  endtask

  initial begin
    int f, ph, thr, pmax;
    kp      = mfps_pkg::PROP_GAIN_RST;
    ki      = mfps_pkg::INTEG_GAIN_RST;
    kd      = mfps_pkg::DERIV_GAIN_RST;
    rep_thr = mfps_pkg::REPORT_THR_RST;
    pos_max = mfps_pkg::POS_MAX_RST;
    for (f = 0; f < FADERS; f++) begin
      tgt[f]      = '0;
      released[f] = 1'b1;
      touched[f]  = 1'b0;
      err_sum[f]  = '0;
      old_err[f]  = '0;
      last_rep[f] = mfps_pkg::LAST_REPORT_RST;
    end
    for (f = 0; f < 16; f++) last_sample[f] = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed requests at reset settings
    push_req(mfps_pkg::CMD_SAMPLE, 0, 0, 1'b0);        // first report of a released fader
    push_req(mfps_pkg::CMD_SAMPLE, 0, 3, 1'b0);        // movement within threshold
    push_req(mfps_pkg::CMD_SAMPLE, 0, -32768, 1'b1);   // negative sample clamps to zero
    push_req(mfps_pkg::CMD_SAMPLE, 0, 32767, 1'b0);    // clamps to position max
    push_req(mfps_pkg::CMD_SAMPLE, 0, 1018, 1'b0);     // just beyond threshold
    push_req(mfps_pkg::CMD_TARGET, 1, 32767, 1'b0);
    push_req(mfps_pkg::CMD_TARGET, 2, -32768, 1'b1);
    push_req(mfps_pkg::CMD_SAMPLE, 1, 0, 1'b0);        // full forward drive
    push_req(mfps_pkg::CMD_SAMPLE, 2, 1023, 1'b0);     // full reverse drive
    push_req(mfps_pkg::CMD_SAMPLE, 1, 1023, 1'b0);     // zero error, derivative kick
    push_req(mfps_pkg::CMD_SAMPLE, 1, 1020, 1'b0);
    push_req(mfps_pkg::CMD_TOUCH, 1, 0, 1'b1);
    push_req(mfps_pkg::CMD_SAMPLE, 1, 500, 1'b0);      // touched: motor off, report
    push_req(mfps_pkg::CMD_TARGET, 1, 600, 1'b0);      // touch flag survives a new target
    push_req(mfps_pkg::CMD_SAMPLE, 1, 500, 1'b0);
    push_req(mfps_pkg::CMD_TOUCH, 1, 0, 1'b0);
    push_req(mfps_pkg::CMD_SAMPLE, 1, 590, 1'b1);
    push_req(mfps_pkg::CMD_RELEASE, 2, 0, 1'b0);
    push_req(mfps_pkg::CMD_SAMPLE, 2, 700, 1'b0);      // released: motor off, report
    push_req(mfps_pkg::CMD_SAMPLE, 10, 100, 1'b0);     // out of range faders are ignored
    push_req(mfps_pkg::CMD_TARGET, 15, 100, 1'b1);
    push_req(mfps_pkg::CMD_TOUCH, 12, 0, 1'b1);
    push_req(mfps_pkg::CMD_RELEASE, 11, 0, 1'b0);
    push_req(mfps_pkg::CMD_TARGET, 9, 512, 1'b0);
    push_req(mfps_pkg::CMD_SAMPLE, 9, 512, 1'b0);
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      thr  = $urandom_range(0, 1023);
      pmax = $urandom_range(0, 1023);
      case (ph)
        0: write_all(small_gain(), small_gain(), small_gain(), 0, 1023);
        1: write_all(32767, -32768, 32767, 1023, 0);
        2: write_all(-32768, 32767, -32768, thr, pmax);
        3: write_all(small_gain(), $urandom_range(0, 8) - 4, small_gain(),
                     $urandom_range(0, 20), 1023);
        4: write_all(small_gain(), 0, small_gain(), thr, pmax);
        default: write_all($urandom, $urandom, $urandom, thr, pmax);
      endcase
      queue_random(270);
      wait_idle();
    end

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
